>>> sv/bsal_pkg.sv
`timescale 1ns / 1ps

package bsal_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SORTED = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS_POS,
		OP_INS_SORT,
		OP_DEL,
		OP_ROT
	} chain_op_t;

	typedef struct packed {
		chain_op_t                 op;
		logic [CMP_W-1:0]          pos;
		logic [COUNT_W-1:0]        count;
		logic signed [DATA_W-1:0]  value;
	} chain_ctrl_t;

endpackage

>>> sv/bsal_in_if.sv
`timescale 1ns / 1ps

interface bsal_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [bsal_pkg::CMD_W-1:0]               cmd;
	logic signed [bsal_pkg::DATA_W-1:0]       value;
	logic [bsal_pkg::POS_W-1:0]               position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface

>>> sv/bsal_out_if.sv
`timescale 1ns / 1ps

interface bsal_out_if;
	logic                                     valid;
	logic                                     ready;
	logic [bsal_pkg::STATUS_W-1:0]            status;
	logic [bsal_pkg::COUNT_W-1:0]             count;
	logic signed [bsal_pkg::DATA_W-1:0]       item_value;
	logic                                     last;

	modport source (output valid, status, count, item_value, last, input ready);
	modport sink (input valid, status, count, item_value, last, output ready);
endinterface

>>> sv/bsal_cell.sv
`timescale 1ns / 1ps

module bsal_cell (
	input  logic                                clk,
	input  logic [bsal_pkg::IDX_W-1:0]          idx,
	input  bsal_pkg::chain_ctrl_t               ctrl,
	input  logic signed [bsal_pkg::DATA_W-1:0]  left,
	input  logic signed [bsal_pkg::DATA_W-1:0]  right,
	input  logic signed [bsal_pkg::DATA_W-1:0]  head,
	input  logic                                sel_in,
	output logic                                sel_out,
	output logic signed [bsal_pkg::DATA_W-1:0]  data
);

	logic signed [bsal_pkg::DATA_W-1:0] data_q;
	logic signed [bsal_pkg::DATA_W-1:0] data_d;
	logic [bsal_pkg::CMP_W-1:0]         idx_w;
	logic [bsal_pkg::CMP_W-1:0]         cnt_w;
	logic                               occupied;
	logic                               ge;
	logic                               sel;

	always_comb begin
		idx_w    = bsal_pkg::CMP_W'(idx);
		cnt_w    = bsal_pkg::CMP_W'(ctrl.count);
		occupied = idx_w < cnt_w;
		ge       = !occupied || (data_q >= ctrl.value);
		case (ctrl.op)
			bsal_pkg::OP_INS_POS:  sel = idx_w >= ctrl.pos;
			bsal_pkg::OP_INS_SORT: sel = sel_in || ge;
			default:               sel = 1'b0;
		endcase
		data_d = data_q;
		case (ctrl.op)
			bsal_pkg::OP_INS_POS, bsal_pkg::OP_INS_SORT: begin
				if (sel_in)
					data_d = left;
				else if (sel)
					data_d = ctrl.value;
			end
			bsal_pkg::OP_DEL: begin
				if (idx_w >= ctrl.pos)
					data_d = right;
			end
			bsal_pkg::OP_ROT: begin
				if (idx_w + bsal_pkg::CMP_W'(1) == cnt_w)
					data_d = head;
				else
					data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign sel_out = sel;
	assign data    = data_q;

endmodule

>>> sv/bsal_chain.sv
`timescale 1ns / 1ps

module bsal_chain (
	input  logic                                clk,
	input  bsal_pkg::chain_ctrl_t               ctrl,
	output logic signed [bsal_pkg::DATA_W-1:0]  head
);

	logic signed [bsal_pkg::DATA_W-1:0] cell_data [bsal_pkg::CAPACITY];
	logic                               sel_chain [bsal_pkg::CAPACITY+1];

	assign sel_chain[0] = 1'b0;

	for (genvar i = 0; i < bsal_pkg::CAPACITY; i++) begin : g_cell
		logic signed [bsal_pkg::DATA_W-1:0] left_w;
		logic signed [bsal_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = ctrl.value;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end

		if (i == bsal_pkg::CAPACITY - 1) begin : g_end
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		bsal_cell u_cell (
			.clk     (clk),
			.idx     (bsal_pkg::IDX_W'(i)),
			.ctrl    (ctrl),
			.left    (left_w),
			.right   (right_w),
			.head    (cell_data[0]),
			.sel_in  (sel_chain[i]),
			.sel_out (sel_chain[i+1]),
			.data    (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

>>> sv/bounded_sorted_array_list.sv
`timescale 1ns / 1ps

// Bounded list of up to sixteen signed 32-bit values, held in a row of cells.
// Commands arrive on req (cmd, value, position) and results leave on rsp
// (status, count, item_value, last), both with a valid/ready handshake; an
// item moves on a clock edge at which valid and ready are both high.
// In append, positional insert, sorted insert and delete, every cell
// compares and shifts at once, and the sorted insert finds its place
// through a flag that ripples along the row. The result is registered and
// shown the cycle after the command is accepted. A dump rotates the row
// through its head cell and emits one result a cycle while rsp is not
// stalled, count results in all, after the state moves to dump; no
// command is taken until the last is loaded. A dump of an empty list
// gives one result in the cycle after it, as any command.
// A stalled rsp holds its result and blocks req until it is taken.
// Asynchronous reset empties the list and clears the result register; the
// cell contents are left as they are and are never read before written.

module bounded_sorted_array_list (
	input  logic          clk,
	input  logic          arst_n,
	bsal_in_if.sink       req,
	bsal_out_if.source    rsp
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t                             state_q;
	logic [bsal_pkg::COUNT_W-1:0]       entry_count_q;
	logic [bsal_pkg::IDX_W-1:0]         dump_idx_q;
	logic                               out_valid_q;
	logic [bsal_pkg::STATUS_W-1:0]      status_q;
	logic [bsal_pkg::COUNT_W-1:0]       count_q;
	logic signed [bsal_pkg::DATA_W-1:0] value_q;
	logic                               last_q;

	bsal_pkg::chain_ctrl_t              ctrl;
	logic signed [bsal_pkg::DATA_W-1:0] head;
	logic                               slot_free;
	logic                               accept;
	logic                               full;
	logic                               dump_last;
	logic [bsal_pkg::CMP_W-1:0]         cnt_ext;
	logic [bsal_pkg::CMP_W-1:0]         pos_ext;
	logic                               load;
	logic                               go_dump;
	logic [bsal_pkg::STATUS_W-1:0]      status_d;
	logic [bsal_pkg::COUNT_W-1:0]       count_d;
	logic signed [bsal_pkg::DATA_W-1:0] value_d;
	logic                               last_d;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign full      = entry_count_q == bsal_pkg::COUNT_W'(bsal_pkg::CAPACITY);
	assign cnt_ext   = bsal_pkg::CMP_W'(entry_count_q);
	assign pos_ext   = bsal_pkg::CMP_W'(req.position);
	assign dump_last = bsal_pkg::CMP_W'(dump_idx_q) + bsal_pkg::CMP_W'(1) == cnt_ext;

	always_comb begin
		ctrl.op    = bsal_pkg::OP_NONE;
		ctrl.pos   = cnt_ext;
		ctrl.count = entry_count_q;
		ctrl.value = req.value;
		load       = 1'b0;
		go_dump    = 1'b0;
		status_d   = bsal_pkg::ST_OK;
		count_d    = entry_count_q;
		value_d    = '0;
		last_d     = 1'b1;
		if (state_q == S_DUMP) begin
			if (slot_free) begin
				ctrl.op = bsal_pkg::OP_ROT;
				load    = 1'b1;
				value_d = head;
				last_d  = dump_last;
			end
		end else if (accept) begin
			load = 1'b1;
			case (req.cmd)
				bsal_pkg::CMD_APPEND: begin
					if (full) begin
						status_d = bsal_pkg::ST_FULL;
					end else begin
						ctrl.op = bsal_pkg::OP_INS_POS;
						count_d = entry_count_q + bsal_pkg::COUNT_W'(1);
					end
				end
				bsal_pkg::CMD_INSERT: begin
					if (full) begin
						status_d = bsal_pkg::ST_FULL;
					end else if (pos_ext > cnt_ext) begin
						status_d = bsal_pkg::ST_BADPOS;
					end else begin
						ctrl.op  = bsal_pkg::OP_INS_POS;
						ctrl.pos = pos_ext;
						count_d  = entry_count_q + bsal_pkg::COUNT_W'(1);
					end
				end
				bsal_pkg::CMD_SORTED: begin
					if (full) begin
						status_d = bsal_pkg::ST_FULL;
					end else begin
						ctrl.op = bsal_pkg::OP_INS_SORT;
						count_d = entry_count_q + bsal_pkg::COUNT_W'(1);
					end
				end
				bsal_pkg::CMD_DELETE: begin
					if (pos_ext >= cnt_ext) begin
						status_d = bsal_pkg::ST_BADPOS;
					end else begin
						ctrl.op  = bsal_pkg::OP_DEL;
						ctrl.pos = pos_ext;
						count_d  = entry_count_q - bsal_pkg::COUNT_W'(1);
					end
				end
				bsal_pkg::CMD_DUMP: begin
					if (entry_count_q != '0) begin
						load    = 1'b0;
						go_dump = 1'b1;
					end
				end
				default: load = 1'b1;
			endcase
		end
	end

	bsal_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			dump_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= '0;
			count_q       <= '0;
			value_q       <= '0;
			last_q        <= 1'b0;
		end else begin
			entry_count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
				count_q     <= count_d;
				value_q     <= value_d;
				last_q      <= last_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (go_dump) begin
						state_q    <= S_DUMP;
						dump_idx_q <= '0;
					end
				end
				S_DUMP: begin
					if (slot_free) begin
						dump_idx_q <= dump_idx_q + bsal_pkg::IDX_W'(1);
						if (dump_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_q;
	assign rsp.item_value = value_q;
	assign rsp.last       = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= bsal_pkg::COUNT_W'(bsal_pkg::CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(entry_count_q))
		else $error("entry count changed without a command");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> entry_count_q != '0)
		else $error("dump running on an empty list");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd != bsal_pkg::CMD_DUMP |=> rsp.valid && rsp.last)
		else $error("command gave no final result");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP && slot_free && dump_last |=> state_q == S_IDLE && rsp.last)
		else $error("dump did not end on its last item");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [bsal_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
	localparam logic [bsal_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [bsal_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int N_DIRECTED = 25;

	typedef struct {
		logic [bsal_pkg::STATUS_W-1:0]      status;
		logic [bsal_pkg::COUNT_W-1:0]       count;
		logic signed [bsal_pkg::DATA_W-1:0] item_value;
		logic                               last;
	} list_result_t;

	typedef struct {
		logic [bsal_pkg::CMD_W-1:0]         cmd;
		logic signed [bsal_pkg::DATA_W-1:0] value;
		logic [bsal_pkg::POS_W-1:0]         position;
		int                                 reps;
		bit                                 typed;
		logic [bsal_pkg::STATUS_W-1:0]      status;
		logic [bsal_pkg::COUNT_W-1:0]       count;
	} list_row_t;

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	logic signed [bsal_pkg::DATA_W-1:0] list_vals[$];
	list_result_t                       pending_results[$];

	bsal_in_if  req_if ();
	bsal_out_if rsp_if ();

	bounded_sorted_array_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Rows with typed = 0 are checked against the list model only.
	list_row_t directed_rows [N_DIRECTED] = '{
		'{bsal_pkg::CMD_DUMP,   32'sd0,        6'd0,  1,  1'b1, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd0,  1,  1'b1, bsal_pkg::ST_BADPOS, 5'd0},
		'{bsal_pkg::CMD_INSERT, 32'sd7,        6'd1,  1,  1'b1, bsal_pkg::ST_BADPOS, 5'd0},
		'{bsal_pkg::CMD_INSERT, -32'sd7,       6'd63, 1,  1'b1, bsal_pkg::ST_BADPOS, 5'd0},
		'{bsal_pkg::CMD_APPEND, 32'sh7FFFFFFF, 6'd0,  1,  1'b1, bsal_pkg::ST_OK,     5'd1},
		'{bsal_pkg::CMD_APPEND, 32'sh80000000, 6'd63, 1,  1'b1, bsal_pkg::ST_OK,     5'd2},
		'{bsal_pkg::CMD_SORTED, 32'sd0,        6'd0,  1,  1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_INSERT, 32'sd5,        6'd3,  1,  1'b1, bsal_pkg::ST_OK,     5'd4},
		'{bsal_pkg::CMD_SORTED, -32'sd1,       6'd0,  1,  1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_SORTED, 32'sd0,        6'd0,  1,  1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_INSERT, -32'sd5,       6'd0,  1,  1'b1, bsal_pkg::ST_OK,     5'd7},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd7,  1,  1'b1, bsal_pkg::ST_BADPOS, 5'd7},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd6,  1,  1'b1, bsal_pkg::ST_OK,     5'd6},
		'{CMD_RSVD_5,           -32'sd1,       6'd63, 1,  1'b1, bsal_pkg::ST_OK,     5'd6},
		'{CMD_RSVD_6,           32'sd1,        6'd0,  1,  1'b1, bsal_pkg::ST_OK,     5'd6},
		'{CMD_RSVD_7,           32'sh55555555, 6'd2,  1,  1'b1, bsal_pkg::ST_OK,     5'd6},
		'{bsal_pkg::CMD_DUMP,   32'sd0,        6'd0,  1,  1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_APPEND, 32'sh55555555, 6'd0,  10, 1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_APPEND, 32'sd1,        6'd0,  1,  1'b1, bsal_pkg::ST_FULL,   5'd16},
		'{bsal_pkg::CMD_INSERT, 32'sd1,        6'd63, 1,  1'b1, bsal_pkg::ST_FULL,   5'd16},
		'{bsal_pkg::CMD_SORTED, 32'sd1,        6'd0,  1,  1'b1, bsal_pkg::ST_FULL,   5'd16},
		'{bsal_pkg::CMD_DUMP,   32'sd0,        6'd0,  1,  1'b0, bsal_pkg::ST_OK,     5'd0},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd0,  1,  1'b1, bsal_pkg::ST_OK,     5'd15},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd15, 1,  1'b1, bsal_pkg::ST_BADPOS, 5'd15},
		'{bsal_pkg::CMD_DELETE, 32'sd0,        6'd14, 1,  1'b1, bsal_pkg::ST_OK,     5'd14}
	};

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_if.ready <= 1'b0;
		else
			rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic void apply_list_cmd(input logic [bsal_pkg::CMD_W-1:0] cmd,
			input logic signed [bsal_pkg::DATA_W-1:0] value,
			input logic [bsal_pkg::POS_W-1:0] position);
		logic [bsal_pkg::STATUS_W-1:0] st;
		int idx;
		int n;
		st = bsal_pkg::ST_OK;
		n = list_vals.size();
		case (cmd)
			bsal_pkg::CMD_APPEND: begin
				if (n >= bsal_pkg::CAPACITY)
					st = bsal_pkg::ST_FULL;
				else
					list_vals.push_back(value);
			end
			bsal_pkg::CMD_INSERT: begin
				if (n >= bsal_pkg::CAPACITY)
					st = bsal_pkg::ST_FULL;
				else if (position > n)
					st = bsal_pkg::ST_BADPOS;
				else
					list_vals.insert(position, value);
			end
			bsal_pkg::CMD_SORTED: begin
				if (n >= bsal_pkg::CAPACITY) begin
					st = bsal_pkg::ST_FULL;
				end else begin
					idx = 0;
					while (idx < n && list_vals[idx] < value)
						idx++;
					list_vals.insert(idx, value);
				end
			end
			bsal_pkg::CMD_DELETE: begin
				if (position >= n)
					st = bsal_pkg::ST_BADPOS;
				else
					list_vals.delete(position);
			end
			bsal_pkg::CMD_DUMP: begin
				if (n == 0) begin
					pending_results.push_back('{bsal_pkg::ST_OK, '0, '0, 1'b1});
				end else begin
					for (idx = 0; idx < n; idx++)
						pending_results.push_back('{bsal_pkg::ST_OK,
							bsal_pkg::COUNT_W'(n), list_vals[idx], idx == n - 1});
				end
				return;
			end
			default: begin
			end
		endcase
		pending_results.push_back('{st, bsal_pkg::COUNT_W'(list_vals.size()), '0, 1'b1});
	endfunction

	task automatic send_cmd(input logic [bsal_pkg::CMD_W-1:0] cmd,
			input logic signed [bsal_pkg::DATA_W-1:0] value,
			input logic [bsal_pkg::POS_W-1:0] position);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.cmd      <= cmd;
		req_if.value    <= value;
		req_if.position <= position;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		apply_list_cmd(cmd, value, position);
	endtask

	task automatic drain_results;
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic send_random_cmd;
		logic [bsal_pkg::CMD_W-1:0]         cmd;
		logic signed [bsal_pkg::DATA_W-1:0] value;
		logic [bsal_pkg::POS_W-1:0]         position;
		int n;
		int r;
		n = list_vals.size();
		r = $urandom_range(99);
		if (r < 8)
			cmd = bsal_pkg::CMD_DUMP;
		else if (r < 11)
			cmd = CMD_RSVD_5 + bsal_pkg::CMD_W'($urandom_range(2));
		else if ($urandom_range(bsal_pkg::CAPACITY + 2) >= n)
			case ($urandom_range(2))
				0: cmd = bsal_pkg::CMD_APPEND;
				1: cmd = bsal_pkg::CMD_INSERT;
				default: cmd = bsal_pkg::CMD_SORTED;
			endcase
		else
			cmd = bsal_pkg::CMD_DELETE;
		case ($urandom_range(3))
			0: value = $urandom();
			1: value = int'($urandom_range(6)) - 3;
			2: value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: value = int'($urandom_range(40)) - 20;
		endcase
		if ($urandom_range(9) == 0)
			position = bsal_pkg::POS_W'($urandom_range(63));
		else if (cmd == bsal_pkg::CMD_DELETE && n > 0)
			position = bsal_pkg::POS_W'($urandom_range(n - 1));
		else
			position = bsal_pkg::POS_W'($urandom_range(n));
		send_cmd(cmd, value, position);
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d count %0d value %0d last %0d",
					rsp_if.status, rsp_if.count, rsp_if.item_value, rsp_if.last);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_if.status);
					mismatch_count++;
				end
				if (rsp_if.count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, rsp_if.count);
					mismatch_count++;
				end
				if (rsp_if.item_value !== want.item_value) begin
					$error("item_value: expected %0d, actual %0d", want.item_value,
						rsp_if.item_value);
					mismatch_count++;
				end
				if (rsp_if.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, rsp_if.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int row;
		int k;
		int phase;
		src_idle_pct = 38;
		snk_idle_pct = 77;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.cmd <= bsal_pkg::CMD_APPEND;
		req_if.value <= '0;
		req_if.position <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < N_DIRECTED; row++) begin
			for (k = 0; k < directed_rows[row].reps; k++) begin
				send_cmd(directed_rows[row].cmd, directed_rows[row].value,
					directed_rows[row].position);
				if (directed_rows[row].typed) begin
					void'(pending_results.pop_back());
					pending_results.push_back('{directed_rows[row].status,
						directed_rows[row].count, '0, 1'b1});
				end
			end
		end
		drain_results();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 38;
					snk_idle_pct = 77;
				end
				1: begin
					src_idle_pct = 77;
					snk_idle_pct = 38;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				send_random_cmd();
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/bsal_pkg.sv
sv/bsal_in_if.sv
sv/bsal_out_if.sv
sv/bsal_cell.sv
sv/bsal_chain.sv
sv/bounded_sorted_array_list.sv
dv/tb_top.sv
